### rtl/prd_pkg.sv
package prd_pkg;

    // fixed-point format of the result
    localparam int FRACTION_BITS = 14;
    localparam int MAX_DIMENSION = 4096;

    // field and register widths
    localparam int PIX_W  = 12;
    localparam int DIM_W  = 13;
    localparam int ASP_W  = 16;
    localparam int FOV_W  = 20;
    localparam int CFG_W  = 20;
    localparam int CIDX_W = 2;
    localparam int DIR_W  = 16;
    localparam int DIRZ_W = 15;

    // datapath widths
    localparam int MAG_W      = 31;
    localparam int SUM_W      = 64;
    localparam int LEN_W      = 32;
    localparam int Q_W        = FRACTION_BITS + 1;
    localparam int NUM_W      = MAG_W + FRACTION_BITS + 1;
    localparam int SQRT_STEPS = SUM_W / 2;

    // register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_ASPECT_RATIO = 2'd2,
        CFG_FOV_SCALE    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } in_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic [DIRZ_W-1:0]       dir_z;
    } out_t;

    // state handed along the square root chain
    typedef struct packed {
        logic [SUM_W-1:0] v;
        logic [SUM_W-1:0] res;
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic [MAG_W-1:0] mz;
        logic             sx;
        logic             sy;
    } sqrt_state_t;

    // one component of the divide chain
    typedef struct packed {
        logic [LEN_W-1:0] rem;
        logic [Q_W-1:0]   low;
        logic [Q_W-1:0]   q;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [2:0]  lane;
        logic [LEN_W-1:0] len;
        logic             sx;
        logic             sy;
    } div_state_t;

endpackage

### rtl/prd_sqrt_cell.sv
module prd_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  prd_pkg::sqrt_state_t in_state,
    output logic                 out_valid,
    output prd_pkg::sqrt_state_t out_state
);

    localparam int SW = prd_pkg::SUM_W;
    localparam logic [SW-1:0] STEP_BIT = SW'(1) << BIT_POS;

    logic                 valid_reg;
    prd_pkg::sqrt_state_t state_reg;
    prd_pkg::sqrt_state_t state_next;
    logic [SW:0]          trial;
    logic                 take;

    // one restoring square root step
    always_comb
    begin
        trial      = {1'b0, in_state.res} + {1'b0, STEP_BIT};
        take       = {1'b0, in_state.v} >= trial;
        state_next = in_state;
        if (take)
        begin
            state_next.v   = in_state.v - trial[SW-1:0];
            state_next.res = (in_state.res >> 1) + STEP_BIT;
        end
        else
        begin
            state_next.res = in_state.res >> 1;
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
            state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

### rtl/prd_div_cell.sv
module prd_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                in_valid,
    input  prd_pkg::div_state_t in_state,
    output logic                out_valid,
    output prd_pkg::div_state_t out_state
);

    localparam int LW = prd_pkg::LEN_W;
    localparam int QW = prd_pkg::Q_W;

    logic                valid_reg;
    prd_pkg::div_state_t state_reg;
    prd_pkg::div_state_t state_next;

    // one quotient bit for each of the three components
    always_comb
    begin
        logic [LW:0] t;
        logic [LW:0] diff;
        logic        ge;
        state_next = in_state;
        for (int k = 0; k < 3; k++)
        begin
            t    = {in_state.lane[k].rem, in_state.lane[k].low[QW-1]};
            diff = t - {1'b0, in_state.len};
            ge   = t >= {1'b0, in_state.len};
            state_next.lane[k].rem = ge ? diff[LW-1:0] : t[LW-1:0];
            state_next.lane[k].low = {in_state.lane[k].low[QW-2:0], 1'b0};
            state_next.lane[k].q   = {in_state.lane[k].q[QW-2:0], ge};
        end
    end

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (advance)
            state_reg <= state_next;
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

### rtl/primary_ray_direction_core.sv
// Pinhole camera primary ray unit: each transfer on the input carries one pixel
// coordinate and produces one unit direction (Q1.14, up and forward positive).
// A new pixel is taken every cycle; the whole pipeline holds only while a
// finished result is waiting and the output is stalled. Most of the pipeline
// is the 32-cell square root chain and the 15-cell divide chain that
// normalize the vector. Image size, aspect ratio and field-of-view scale
// must be written through the configuration port only while no pixel is in
// flight; the block itself does not enforce this. A dimension of zero counts
// as one and one above 4096 counts as 4096.
module primary_ray_direction_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  prd_pkg::in_t                  in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output prd_pkg::out_t                 out_data,
    input  logic                          cfg_we,
    input  logic [prd_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [prd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int FB     = prd_pkg::FRACTION_BITS;
    localparam int DW     = prd_pkg::DIM_W;
    localparam int AW     = prd_pkg::ASP_W;
    localparam int FW     = prd_pkg::FOV_W;
    localparam int MW     = prd_pkg::MAG_W;
    localparam int SW     = prd_pkg::SUM_W;
    localparam int LW     = prd_pkg::LEN_W;
    localparam int QW     = prd_pkg::Q_W;
    localparam int NW     = prd_pkg::NUM_W;
    localparam int XW     = prd_pkg::DIR_W;
    localparam int ZW     = prd_pkg::DIRZ_W;
    localparam int STEPS  = prd_pkg::SQRT_STEPS;
    localparam int P1_W   = 2 * DW;
    localparam int MXA_W  = P1_W + FW;
    localparam int NYWA_W = P1_W + AW;
    localparam int MX_W   = MXA_W + 12;
    localparam int MY_W   = NYWA_W + FW;
    localparam int MZ_W   = P1_W + 24;
    localparam int OR_W   = MY_W;
    localparam int BL_W   = $clog2(OR_W + 1);
    localparam int SH_W   = $clog2(OR_W - MW + 1);
    localparam int SQ_W   = 2 * MW;
    localparam logic [QW-1:0] ONE = QW'(1) << FB;

    // configuration registers
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic [AW-1:0] aspect_reg;
    logic [FW-1:0] fov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(1920);
            height_reg <= DW'(1080);
            aspect_reg <= AW'(7282);
            fov_reg    <= FW'(4096);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prd_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[DW-1:0];
                prd_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data[DW-1:0];
                prd_pkg::CFG_ASPECT_RATIO: aspect_reg <= cfg_data[AW-1:0];
                prd_pkg::CFG_FOV_SCALE:    fov_reg    <= cfg_data[FW-1:0];
                default: ;
            endcase
        end
    end

    // clamped dimensions
    logic [DW-1:0] w_c;
    logic [DW-1:0] h_c;

    always_comb
    begin
        if (width_reg == '0)
            w_c = DW'(1);
        else if (width_reg > DW'(prd_pkg::MAX_DIMENSION))
            w_c = DW'(prd_pkg::MAX_DIMENSION);
        else
            w_c = width_reg;
        if (height_reg == '0)
            h_c = DW'(1);
        else if (height_reg > DW'(prd_pkg::MAX_DIMENSION))
            h_c = DW'(prd_pkg::MAX_DIMENSION);
        else
            h_c = height_reg;
    end

    // global hold: the pipeline moves unless a result waits on a stalled output
    logic          advance;
    logic          out_valid_reg;
    prd_pkg::out_t out_data_reg;

    assign advance  = !(out_valid_reg && out_stall);
    assign in_stall = !advance;

    // stage 1: centered numerators as sign and magnitude
    logic          st1_valid_reg;
    logic [DW-1:0] st1_nx_reg, st1_ny_reg;
    logic          st1_sx_reg, st1_sy_reg;
    logic [DW-1:0] two_x, two_y;
    logic [DW-1:0] nx_next, ny_next;
    logic          sx_next, sy_next;

    always_comb
    begin
        two_x = {in_data.pixel_x, 1'b1};
        two_y = {in_data.pixel_y, 1'b1};
        if (two_x >= w_c)
        begin
            nx_next = two_x - w_c;
            sx_next = 1'b0;
        end
        else
        begin
            nx_next = w_c - two_x;
            sx_next = 1'b1;
        end
        if (h_c >= two_y)
        begin
            ny_next = h_c - two_y;
            sy_next = 1'b0;
        end
        else
        begin
            ny_next = two_y - h_c;
            sy_next = 1'b1;
        end
    end

    // stage 2: first products
    logic              st2_valid_reg;
    logic [P1_W-1:0]   st2_nxh_reg, st2_nyw_reg, st2_wh_reg;
    logic              st2_sx_reg, st2_sy_reg;

    // stage 3: second products
    logic              st3_valid_reg;
    logic [MXA_W-1:0]  st3_mxa_reg;
    logic [NYWA_W-1:0] st3_nywa_reg;
    logic [MZ_W-1:0]   st3_mz_reg;
    logic              st3_sx_reg, st3_sy_reg;

    // stage 4: full magnitudes
    logic              st4_valid_reg;
    logic [MX_W-1:0]   st4_mx_reg;
    logic [MY_W-1:0]   st4_my_reg;
    logic [MZ_W-1:0]   st4_mz_reg;
    logic              st4_sx_reg, st4_sy_reg;

    // stage 5: common shift amount
    logic              st5_valid_reg;
    logic [MX_W-1:0]   st5_mx_reg;
    logic [MY_W-1:0]   st5_my_reg;
    logic [MZ_W-1:0]   st5_mz_reg;
    logic              st5_sx_reg, st5_sy_reg;
    logic [SH_W-1:0]   st5_shift_reg;
    logic [SH_W-1:0]   shift_next;
    logic [OR_W-1:0]   or_all;
    logic [BL_W-1:0]   bitlen;

    always_comb
    begin
        or_all = OR_W'(st4_mx_reg) | st4_my_reg | OR_W'(st4_mz_reg);
        bitlen = '0;
        for (int i = 0; i < OR_W; i++)
        begin
            if (or_all[i])
                bitlen = BL_W'(i + 1);
        end
        if (bitlen > BL_W'(MW))
            shift_next = SH_W'(bitlen - BL_W'(MW));
        else
            shift_next = '0;
    end

    // stage 6: shifted magnitudes
    logic              st6_valid_reg;
    logic [MW-1:0]     st6_mx_reg, st6_my_reg, st6_mz_reg;
    logic              st6_sx_reg, st6_sy_reg;

    // stage 7: squares
    logic              st7_valid_reg;
    logic [SQ_W-1:0]   st7_qx_reg, st7_qy_reg, st7_qz_reg;
    logic [MW-1:0]     st7_mx_reg, st7_my_reg, st7_mz_reg;
    logic              st7_sx_reg, st7_sy_reg;

    // stage 8: sum of squares, head of the square root chain
    logic                 st8_valid_reg;
    prd_pkg::sqrt_state_t st8_state_reg;

    // stages 1 to 8 valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
            st6_valid_reg <= 1'b0;
            st7_valid_reg <= 1'b0;
            st8_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st1_valid_reg <= in_valid;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            st5_valid_reg <= st4_valid_reg;
            st6_valid_reg <= st5_valid_reg;
            st7_valid_reg <= st6_valid_reg;
            st8_valid_reg <= st7_valid_reg;
        end
    end

    // stages 1 to 8 payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_nx_reg <= nx_next;
            st1_ny_reg <= ny_next;
            st1_sx_reg <= sx_next;
            st1_sy_reg <= sy_next;

            st2_nxh_reg <= P1_W'(st1_nx_reg) * P1_W'(h_c);
            st2_nyw_reg <= P1_W'(st1_ny_reg) * P1_W'(w_c);
            st2_wh_reg  <= P1_W'(w_c) * P1_W'(h_c);
            st2_sx_reg  <= st1_sx_reg;
            st2_sy_reg  <= st1_sy_reg;

            st3_mxa_reg  <= MXA_W'(st2_nxh_reg) * MXA_W'(fov_reg);
            st3_nywa_reg <= NYWA_W'(st2_nyw_reg) * NYWA_W'(aspect_reg);
            st3_mz_reg   <= {st2_wh_reg, 24'd0};
            st3_sx_reg   <= st2_sx_reg;
            st3_sy_reg   <= st2_sy_reg;

            st4_mx_reg <= {st3_mxa_reg, 12'd0};
            st4_my_reg <= MY_W'(st3_nywa_reg) * MY_W'(fov_reg);
            st4_mz_reg <= st3_mz_reg;
            st4_sx_reg <= st3_sx_reg;
            st4_sy_reg <= st3_sy_reg;

            st5_mx_reg    <= st4_mx_reg;
            st5_my_reg    <= st4_my_reg;
            st5_mz_reg    <= st4_mz_reg;
            st5_sx_reg    <= st4_sx_reg;
            st5_sy_reg    <= st4_sy_reg;
            st5_shift_reg <= shift_next;

            st6_mx_reg <= MW'(st5_mx_reg >> st5_shift_reg);
            st6_my_reg <= MW'(st5_my_reg >> st5_shift_reg);
            st6_mz_reg <= MW'(st5_mz_reg >> st5_shift_reg);
            st6_sx_reg <= st5_sx_reg;
            st6_sy_reg <= st5_sy_reg;

            st7_qx_reg <= SQ_W'(st6_mx_reg) * SQ_W'(st6_mx_reg);
            st7_qy_reg <= SQ_W'(st6_my_reg) * SQ_W'(st6_my_reg);
            st7_qz_reg <= SQ_W'(st6_mz_reg) * SQ_W'(st6_mz_reg);
            st7_mx_reg <= st6_mx_reg;
            st7_my_reg <= st6_my_reg;
            st7_mz_reg <= st6_mz_reg;
            st7_sx_reg <= st6_sx_reg;
            st7_sy_reg <= st6_sy_reg;

            st8_state_reg.v   <= SW'(st7_qx_reg) + SW'(st7_qy_reg) + SW'(st7_qz_reg);
            st8_state_reg.res <= '0;
            st8_state_reg.mx  <= st7_mx_reg;
            st8_state_reg.my  <= st7_my_reg;
            st8_state_reg.mz  <= st7_mz_reg;
            st8_state_reg.sx  <= st7_sx_reg;
            st8_state_reg.sy  <= st7_sy_reg;
        end
    end

    // square root chain, one result bit per cell
    prd_pkg::sqrt_state_t sq_state [0:STEPS];
    logic                 sq_valid [0:STEPS];

    assign sq_state[0] = st8_state_reg;
    assign sq_valid[0] = st8_valid_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_sqrt
        prd_sqrt_cell #(
            .BIT_POS (SW - 2 - 2 * i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (sq_valid[i]),
            .in_state  (sq_state[i]),
            .out_valid (sq_valid[i+1]),
            .out_state (sq_state[i+1])
        );
    end

    // divide setup: rounded numerators and length
    logic                st9_valid_reg;
    prd_pkg::div_state_t st9_state_reg;
    prd_pkg::div_state_t st9_next;

    always_comb
    begin
        logic [LW-1:0] len;
        logic [MW-1:0] mag [0:2];
        logic [NW-1:0] num;
        len = sq_state[STEPS].res[LW-1:0];
        if (len == '0)
            len = LW'(1);
        mag[0] = sq_state[STEPS].mx;
        mag[1] = sq_state[STEPS].my;
        mag[2] = sq_state[STEPS].mz;
        st9_next.len = len;
        st9_next.sx  = sq_state[STEPS].sx;
        st9_next.sy  = sq_state[STEPS].sy;
        for (int k = 0; k < 3; k++)
        begin
            num = (NW'(mag[k]) << FB) + NW'(len >> 1);
            st9_next.lane[k].rem = LW'(num[NW-1:QW]);
            st9_next.lane[k].low = num[QW-1:0];
            st9_next.lane[k].q   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st9_valid_reg <= 1'b0;
        else if (advance)
            st9_valid_reg <= sq_valid[STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            st9_state_reg <= st9_next;
    end

    // divide chain, one quotient bit per cell
    prd_pkg::div_state_t dv_state [0:QW];
    logic                dv_valid [0:QW];

    assign dv_state[0] = st9_state_reg;
    assign dv_valid[0] = st9_valid_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        prd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_valid  (dv_valid[j]),
            .in_state  (dv_state[j]),
            .out_valid (dv_valid[j+1]),
            .out_state (dv_state[j+1])
        );
    end

    // saturate, apply sign, output register
    prd_pkg::out_t out_next;

    always_comb
    begin
        logic [QW-1:0] qs [0:2];
        for (int k = 0; k < 3; k++)
        begin
            qs[k] = dv_state[QW].lane[k].q;
            if (qs[k] > ONE)
                qs[k] = ONE;
        end
        out_next.dir_x = dv_state[QW].sx ? -XW'(qs[0]) : XW'(qs[0]);
        out_next.dir_y = dv_state[QW].sy ? -XW'(qs[1]) : XW'(qs[1]);
        out_next.dir_z = ZW'(qs[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= dv_valid[QW];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_data_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    // forward component never vanishes after the common shift
    a_mz_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        st6_valid_reg |-> (st6_mz_reg != '0))
        else $error("forward magnitude lost in normalizing shift");

    // a summed item enters the square root chain on the next move
    a_sqrt_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && st8_valid_reg) |=> sq_valid[1])
        else $error("item dropped entering square root chain");

    // forward-lane divide remainder stays below the length
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[QW] |-> (dv_state[QW].lane[2].rem < dv_state[QW].len))
        else $error("divide remainder out of range");

    // dir_z and dir_x stay within the unit range
    a_dir_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.dir_z <= ZW'(ONE)))
        else $error("dir_z above one");

    a_dir_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (($signed(out_data_reg.dir_x) <= $signed(XW'(ONE)))
            && ($signed(out_data_reg.dir_x) >= -$signed(XW'(ONE)))))
        else $error("dir_x outside unit range");
`endif

endmodule
